// ===== src/tmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and codes for the thermostat mode controller.
// ----------------------------------------------------------------------------
package tmc_pkg;

    typedef logic [2:0] t_state;

    // Controller states
    localparam t_state ST_IDLE  = 3'd0;
    localparam t_state ST_FAN   = 3'd1;
    localparam t_state ST_AHEAT = 3'd2;
    localparam t_state ST_HEAT  = 3'd3;
    localparam t_state ST_ACOOL = 3'd4;
    localparam t_state ST_COOL  = 3'd5;

    // User selection codes for manual evaluation
    localparam logic [2:0] SEL_IDLE = 3'd0;
    localparam logic [2:0] SEL_FAN  = 3'd1;
    localparam logic [2:0] SEL_HEAT = 3'd3;
    localparam logic [2:0] SEL_COOL = 3'd5;

    // Command opcodes
    localparam logic [1:0] OP_MANUAL = 2'd0;
    localparam logic [1:0] OP_AUTO   = 2'd1;
    localparam logic [1:0] OP_TOUCH  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_INACTIVITY = 2'd0;
    localparam logic [1:0] CFG_REVERSAL   = 2'd1;
    localparam logic [1:0] CFG_REPEAT     = 2'd2;
    localparam logic [1:0] CFG_MARGIN     = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] RST_INACTIVITY = 32'd70000;
    localparam logic [31:0] RST_REVERSAL   = 32'd480000;
    localparam logic [31:0] RST_REPEAT     = 32'd300000;
    localparam logic [9:0]  RST_MARGIN     = 10'd10;

    typedef struct packed {
        logic [31:0] inactivity_limit_ms;
        logic [31:0] reversal_delay_ms;
        logic [31:0] repeat_delay_ms;
        logic [9:0]  band_margin;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        now_ms;
        logic               locked;
        logic [2:0]         selected_state;
        logic signed [11:0] temperature;
        logic signed [11:0] goal_temperature;
    } t_item;

    typedef struct packed {
        t_state mode;
        t_state heavy_left;
    } t_mode;

    typedef struct packed {
        t_state state;
        t_state last_heavy;
        logic   timed_out;
        logic   delay_holding;
    } t_result;

endpackage

// ===== src/tmc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_cmd_if / tmc_res_if
// Valid/ready channels for controller commands and results.
// ----------------------------------------------------------------------------
interface tmc_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic               locked;
    logic [2:0]         selected_state;
    logic signed [11:0] temperature;
    logic signed [11:0] goal_temperature;

    modport source (
        output valid, opcode, now_ms, locked, selected_state, temperature,
               goal_temperature,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_ms, locked, selected_state, temperature,
               goal_temperature,
        output ready
    );
endinterface

interface tmc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] state;
    logic [2:0] last_heavy;
    logic       timed_out;
    logic       delay_holding;

    modport source (
        output valid, state, last_heavy, timed_out, delay_holding,
        input  ready
    );
    modport sink (
        input  valid, state, last_heavy, timed_out, delay_holding,
        output ready
    );
endinterface

// ===== src/thermostat_mode_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermostat_mode_controller
// Six-state HVAC mode controller with hysteresis band and compressor delay.
// ----------------------------------------------------------------------------
// The block takes one command transaction per clock while the result side
// is not stalled, and returns exactly one result per command through an
// input register and then a result register. The rate is set by the mode
// state update, which closes inside the evaluation stage; the two registers
// separate the channels, so a new command is taken while a finished result
// waits if the input register is empty. Configuration writes take effect on
// the next cycle and are meant to be made while no command is in flight.
// ----------------------------------------------------------------------------
module thermostat_mode_controller
    import tmc_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int TEMP_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tmc_cmd_if.sink               i_cmd,
    tmc_res_if.source             o_res
);

    t_cfg                 cfg;
    t_item                r_item;
    logic                 r_in_valid;
    t_result              r_res;
    logic                 r_out_valid;
    t_mode                r_mode;
    logic [TIME_BITS-1:0] r_heavy_stamp;
    logic [TIME_BITS-1:0] r_inter_stamp;

    t_mode                n_mode;
    logic [TIME_BITS-1:0] n_heavy_stamp;
    logic [TIME_BITS-1:0] n_inter_stamp;
    t_result              n_res;

    logic out_free;
    logic advance;
    logic cmd_take;

    tmc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tmc_eval #(
        .TIME_BITS (TIME_BITS),
        .TEMP_BITS (TEMP_BITS)
    ) u_eval (
        .i_item        (r_item),
        .i_cfg         (cfg),
        .i_mode        (r_mode),
        .i_heavy_stamp (r_heavy_stamp),
        .i_inter_stamp (r_inter_stamp),
        .o_mode        (n_mode),
        .o_heavy_stamp (n_heavy_stamp),
        .o_inter_stamp (n_inter_stamp),
        .o_result      (n_res)
    );

    assign out_free    = !r_out_valid || o_res.ready;
    assign advance     = r_in_valid && out_free;
    assign i_cmd.ready = !r_in_valid || advance;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (cmd_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_item.opcode           <= i_cmd.opcode;
            r_item.now_ms           <= i_cmd.now_ms;
            r_item.locked           <= i_cmd.locked;
            r_item.selected_state   <= i_cmd.selected_state;
            r_item.temperature      <= i_cmd.temperature;
            r_item.goal_temperature <= i_cmd.goal_temperature;
        end
    end

    // Mode state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode.mode       <= ST_IDLE;
            r_mode.heavy_left <= ST_IDLE;
            r_heavy_stamp     <= '0;
            r_inter_stamp     <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (advance) begin
                r_mode        <= n_mode;
                r_heavy_stamp <= n_heavy_stamp;
                r_inter_stamp <= n_inter_stamp;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.state         = r_res.state;
    assign o_res.last_heavy    = r_res.last_heavy;
    assign o_res.timed_out     = r_res.timed_out;
    assign o_res.delay_holding = r_res.delay_holding;

    // A forced idle never reports a hold
    a_timeout_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.timed_out) |->
            (r_res.state == ST_IDLE && !r_res.delay_holding))
        else $error("timeout result not idle");

    // A hold leaves the state awaiting
    a_hold_awaiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.delay_holding) |->
            (r_res.state == ST_AHEAT || r_res.state == ST_ACOOL))
        else $error("hold reported outside an awaiting state");

    // Only heat or cool is ever recorded as left
    a_heavy_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode.heavy_left == ST_IDLE || r_mode.heavy_left == ST_HEAT ||
         r_mode.heavy_left == ST_COOL))
        else $error("bad recorded heavy state");

    // A pending command moves to the result register once it is free
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("pending command did not advance");

endmodule

// ===== src/tmc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_cfg
// Configuration register file: delays, inactivity limit and band margin.
// ----------------------------------------------------------------------------
module tmc_cfg
    import tmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inactivity_limit_ms <= RST_INACTIVITY;
            r_cfg.reversal_delay_ms   <= RST_REVERSAL;
            r_cfg.repeat_delay_ms     <= RST_REPEAT;
            r_cfg.band_margin         <= RST_MARGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INACTIVITY: r_cfg.inactivity_limit_ms <= i_cfg_data;
                CFG_REVERSAL:   r_cfg.reversal_delay_ms   <= i_cfg_data;
                CFG_REPEAT:     r_cfg.repeat_delay_ms     <= i_cfg_data;
                CFG_MARGIN:     r_cfg.band_margin         <= i_cfg_data[9:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/tmc_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_eval
// Single-pass evaluation of one command against the current mode state.
// ----------------------------------------------------------------------------
module tmc_eval
    import tmc_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int TEMP_BITS = 16
) (
    input  t_item                i_item,
    input  t_cfg                 i_cfg,
    input  t_mode                i_mode,
    input  logic [TIME_BITS-1:0] i_heavy_stamp,
    input  logic [TIME_BITS-1:0] i_inter_stamp,
    output t_mode                o_mode,
    output logic [TIME_BITS-1:0] o_heavy_stamp,
    output logic [TIME_BITS-1:0] o_inter_stamp,
    output t_result              o_result
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int WIDE  = 34;
    localparam logic signed [WIDE-1:0] SAT_HI =
        {{(WIDE-TEMP_BITS+1){1'b0}}, {(TEMP_BITS-1){1'b1}}};
    localparam logic signed [WIDE-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [WIDE-1:0] f_sat(input logic signed [WIDE-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI;
        end else if (v < SAT_LO) begin
            return SAT_LO;
        end else begin
            return v;
        end
    endfunction

    function automatic t_state f_active(input t_state s);
        if (s == ST_AHEAT) begin
            return ST_HEAT;
        end else if (s == ST_ACOOL) begin
            return ST_COOL;
        end else begin
            return s;
        end
    endfunction

    function automatic logic [2:0] f_own_sel(input t_state s);
        logic [2:0] sel;
        unique case (s)
            ST_FAN:            sel = SEL_FAN;
            ST_AHEAT, ST_HEAT: sel = SEL_HEAT;
            ST_ACOOL, ST_COOL: sel = SEL_COOL;
            default:           sel = SEL_IDLE;
        endcase
        return sel;
    endfunction

    function automatic logic [31:0] f_delay(input t_state from_s, input t_state to_s,
                                            input t_cfg cfg);
        t_state a;
        t_state b;
        a = f_active(from_s);
        b = f_active(to_s);
        if ((a == ST_HEAT && b == ST_COOL) || (a == ST_COOL && b == ST_HEAT)) begin
            return cfg.reversal_delay_ms;
        end else if ((a == ST_HEAT || a == ST_COOL) && a == b) begin
            return cfg.repeat_delay_ms;
        end else begin
            return '0;
        end
    endfunction

    logic [CMP_W-1:0]       now_ext;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   inter_elapsed;
    logic [TIME_BITS-1:0]   heavy_elapsed;
    logic                   expired;
    logic signed [WIDE-1:0] temp_w;
    logic signed [WIDE-1:0] goal_w;
    logic signed [WIDE-1:0] margin_w;
    logic signed [WIDE-1:0] diff_w;
    logic signed [WIDE-1:0] mag_w;
    logic                   below;
    logic                   above;
    logic                   near;
    logic                   sel_valid;
    t_state                 target;
    t_state                 cur;
    t_state                 next_pre;
    t_state                 delay_to;
    t_state                 heavy_left;
    logic                   moved;
    logic                   run_stage;
    logic                   is_auto;
    logic                   touch;
    logic                   timed_out;
    logic                   record;
    logic                   awaiting;
    logic                   blocked;
    logic [31:0]            delay_ms;

    // Band comparisons
    always_comb begin
        temp_w   = WIDE'(i_item.temperature);
        goal_w   = WIDE'(i_item.goal_temperature);
        margin_w = signed'(WIDE'(i_cfg.band_margin));
        below    = f_sat(temp_w + margin_w) < goal_w;
        above    = f_sat(temp_w - margin_w) > goal_w;
        diff_w   = f_sat(temp_w - goal_w);
        mag_w    = f_sat((diff_w < 0) ? -diff_w : diff_w);
        near     = mag_w < margin_w;
    end

    always_comb begin
        now_ext       = CMP_W'(i_item.now_ms);
        now_t         = now_ext[TIME_BITS-1:0];
        inter_elapsed = now_t - i_inter_stamp;
        expired       = i_item.locked &&
                        (CMP_W'(inter_elapsed) > CMP_W'(i_cfg.inactivity_limit_ms));
    end

    always_comb begin
        unique case (i_item.selected_state)
            SEL_IDLE: begin sel_valid = 1'b1; target = ST_IDLE;  end
            SEL_FAN:  begin sel_valid = 1'b1; target = ST_FAN;   end
            SEL_HEAT: begin sel_valid = 1'b1; target = ST_AHEAT; end
            SEL_COOL: begin sel_valid = 1'b1; target = ST_ACOOL; end
            default:  begin sel_valid = 1'b0; target = ST_IDLE;  end
        endcase
    end

    always_comb begin
        cur       = i_mode.mode;
        next_pre  = cur;
        moved     = 1'b0;
        run_stage = 1'b0;
        is_auto   = 1'b0;
        touch     = 1'b0;
        timed_out = 1'b0;

        unique case (i_item.opcode)
            OP_MANUAL: begin
                if (expired) begin
                    moved     = 1'b1;
                    next_pre  = ST_IDLE;
                    timed_out = 1'b1;
                end else begin
                    run_stage = 1'b1;
                    if (sel_valid && i_item.selected_state != f_own_sel(cur)) begin
                        moved    = 1'b1;
                        next_pre = target;
                    end
                end
            end
            OP_AUTO: begin
                run_stage = 1'b1;
                is_auto   = 1'b1;
                if (expired) begin
                    moved     = 1'b1;
                    next_pre  = ST_IDLE;
                    timed_out = 1'b1;
                end else if (cur == ST_HEAT) begin
                    if (above) begin
                        moved    = 1'b1;
                        next_pre = ST_ACOOL;
                    end else if (near) begin
                        moved    = 1'b1;
                        next_pre = ST_IDLE;
                    end
                end else if (cur == ST_COOL) begin
                    if (below) begin
                        moved    = 1'b1;
                        next_pre = ST_AHEAT;
                    end else if (near) begin
                        moved    = 1'b1;
                        next_pre = ST_IDLE;
                    end
                end else begin
                    moved = 1'b1;
                    if (below) begin
                        next_pre = ST_AHEAT;
                    end else if (above) begin
                        next_pre = ST_ACOOL;
                    end else begin
                        next_pre = ST_IDLE;
                    end
                end
            end
            OP_TOUCH: touch = 1'b1;
            OP_NONE:  ;
        endcase
    end

    // Record the heavy state being left, then run the protection delay
    always_comb begin
        record        = moved && (cur == ST_HEAT || cur == ST_COOL);
        heavy_left    = record ? cur : i_mode.heavy_left;
        o_heavy_stamp = record ? now_t : i_heavy_stamp;
        o_inter_stamp = touch ? now_t : i_inter_stamp;

        delay_to      = is_auto ? next_pre : i_item.selected_state;
        delay_ms      = f_delay(heavy_left, delay_to, i_cfg);
        heavy_elapsed = now_t - o_heavy_stamp;
        blocked       = (CMP_W'(heavy_elapsed) < CMP_W'(delay_ms)) ||
                        (is_auto && i_item.temperature[11]);
        awaiting      = run_stage && (next_pre == ST_AHEAT || next_pre == ST_ACOOL);

        o_mode.mode       = (awaiting && !blocked) ? f_active(next_pre) : next_pre;
        o_mode.heavy_left = heavy_left;

        o_result.state         = o_mode.mode;
        o_result.last_heavy    = heavy_left;
        o_result.timed_out     = timed_out;
        o_result.delay_holding = awaiting && blocked;
    end

endmodule
